FILE: rtl/wual_pkg.sv
// ----------------------------------------------------------------------------
// Wide unsigned integer ALU package
// Shared constants, operation codes and the result item type.
// ----------------------------------------------------------------------------
package wual_pkg;

    localparam int WORD_W         = 64;
    localparam int DEF_WIDTH_BITS = 1024;

    localparam int OPCODE_W = 4;
    localparam int INDEX_W  = 4;
    localparam int SHAMT_W  = 10;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;

    localparam logic [OPCODE_W-1:0] OP_LOAD_A = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_B = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_ADD    = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_SUB    = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_MUL    = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_DIV    = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_MOD    = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_AND    = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_OR     = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_XOR    = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_NOT    = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_NEG    = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_SHL    = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_SHR    = 4'd13;
    localparam logic [OPCODE_W-1:0] OP_CMP    = 4'd14;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               gt;
        logic               eq;
        logic               dz;
    } res_t;

endpackage

FILE: rtl/wual_core.sv
// ----------------------------------------------------------------------------
// Wide unsigned integer ALU core
// Operand and work memories with a word-serial read-modify-write engine.
// ----------------------------------------------------------------------------
module wual_core #(
    parameter int WIDTH_BITS = wual_pkg::DEF_WIDTH_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [wual_pkg::OPCODE_W-1:0] cmd_opcode,
    input  logic [wual_pkg::INDEX_W-1:0]  cmd_word_index,
    input  logic [wual_pkg::WORD_W-1:0]   cmd_data_word,
    input  logic [wual_pkg::SHAMT_W-1:0]  cmd_shift_amount,
    output logic                          res_valid,
    input  logic                          res_ready,
    output wual_pkg::res_t                res_item
);

    localparam int NWORDS = WIDTH_BITS / 64;
    localparam int IDXW   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BITW   = $clog2(WIDTH_BITS);
    localparam int TW     = 8;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NWORDS - 1);
    localparam logic [BITW-1:0] BIT_TOP  = BITW'(WIDTH_BITS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PASS   = 3'd1;
    localparam logic [2:0] ST_FIN    = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_FETCH2 = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_EMIT2  = 3'd6;
    localparam logic [2:0] ST_CMPOUT = 3'd7;

    localparam logic [2:0] PH_SIMPLE = 3'd0;
    localparam logic [2:0] PH_CMP    = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_MUL    = 3'd3;
    localparam logic [2:0] PH_DIV    = 3'd4;

    logic [63:0] a_mem    [NWORDS];
    logic [63:0] b_mem    [NWORDS];
    logic [63:0] res_mem  [NWORDS];
    logic [63:0] rem0_mem [NWORDS];
    logic [63:0] rem1_mem [NWORDS];

    logic [NWORDS-1:0] a_vld_reg, a_vld_next, b_vld_reg, b_vld_next;
    logic [63:0] a_rd, b_rd, r_rd, rem0_rd, rem1_rd;
    logic        a_ok_reg, b_ok_reg;
    logic [IDXW-1:0] a_ra, b_ra, ld_wa, res_wa;
    logic        a_we, b_we, res_we, rem_we, q_we;
    logic [63:0] res_wd, rem0_wd, rem1_wd;

    logic [2:0]      state_reg, state_next, ph_reg, ph_next;
    logic [3:0]      op_reg, op_next;
    logic [9:0]      sh_reg, sh_next;
    logic [IDXW-1:0] k_reg, k_next, widx, widx_d_reg;
    logic [BITW-1:0] bit_reg, bit_next, bit_dec;
    logic            first_reg, first_next, cur_sel_reg, cur_sel_next;
    logic            dz_reg, dz_next, cy_reg, cy_next, sc_reg, sc_next;
    logic            gt_reg, gt_next, done_reg, done_next, nz_reg, nz_next;
    logic            proc_v_reg, ok_d_reg;
    logic [63:0]     opw_reg, opw_next, q_reg, q_next, prev_reg, prev_next;

    logic            desc, shift_op, big, src_ok, accept, in_range, emit_rem;
    logic [TW-1:0]   src_t;
    logic [3:0]      ws;
    logic [5:0]      bs, nbs;
    logic [IDXW-1:0] bword;
    logic [63:0]     a_dat, b_dat, r_dat, cur_rd, c_dat, sh_cur, sv, fw;
    logic [63:0]     m_s, d_s;
    logic [64:0]     t65, m_t, d_t;
    logic            cy_s, cy_p, sc_p;

    assign desc     = (op_reg == wual_pkg::OP_SHR) || (ph_reg == PH_CMP);
    assign widx     = desc ? (LAST_IDX - k_reg) : k_reg;
    assign ws       = sh_reg[9:6];
    assign bs       = sh_reg[5:0];
    assign nbs      = 6'd0 - bs;
    assign shift_op = (op_reg == wual_pkg::OP_SHL) || (op_reg == wual_pkg::OP_SHR);
    assign big      = 32'(sh_reg) >= 32'(WIDTH_BITS);
    assign src_ok   = TW'(k_reg) >= TW'(ws);
    assign src_t    = desc ? (TW'(NWORDS - 1) - TW'(k_reg) + TW'(ws))
                           : (TW'(k_reg) - TW'(ws));
    assign bword    = IDXW'(bit_reg >> 6);
    assign bit_dec  = bit_reg - 1'b1;
    assign in_range = 32'(cmd_word_index) < 32'(NWORDS);
    assign ld_wa    = IDXW'(cmd_word_index);

    always_comb begin
        if (state_reg == ST_FETCH) begin
            a_ra = bword;
            b_ra = bword;
        end else if (ph_reg == PH_SIMPLE && shift_op) begin
            a_ra = src_t[IDXW-1:0];
            b_ra = widx;
        end else begin
            a_ra = widx;
            b_ra = widx;
        end
    end

    assign a_we = (state_reg == ST_IDLE) && cmd_valid && in_range
                  && (cmd_opcode == wual_pkg::OP_LOAD_A);
    assign b_we = (state_reg == ST_IDLE) && cmd_valid && in_range
                  && (cmd_opcode == wual_pkg::OP_LOAD_B);

    always_comb begin
        a_vld_next = a_vld_reg;
        b_vld_next = b_vld_reg;
        if (a_we) begin
            a_vld_next[ld_wa] = 1'b1;
        end
        if (b_we) begin
            b_vld_next[ld_wa] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[ld_wa] <= cmd_data_word;
        end
        a_rd <= a_mem[a_ra];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[ld_wa] <= cmd_data_word;
        end
        b_rd <= b_mem[b_ra];
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[res_wa] <= res_wd;
        end
        r_rd <= res_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (rem_we) begin
            rem0_mem[widx_d_reg] <= rem0_wd;
        end
        rem0_rd <= rem0_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (rem_we) begin
            rem1_mem[widx_d_reg] <= rem1_wd;
        end
        rem1_rd <= rem1_mem[k_reg];
    end

    assign a_dat  = a_ok_reg ? a_rd : '0;
    assign b_dat  = b_ok_reg ? b_rd : '0;
    assign r_dat  = first_reg ? '0 : r_rd;
    assign cur_rd = cur_sel_reg ? rem1_rd : rem0_rd;
    assign c_dat  = first_reg ? '0 : cur_rd;
    assign sh_cur = ok_d_reg ? a_dat : '0;
    assign fw     = (ph_reg == PH_MUL) ? b_dat : a_dat;

    always_comb begin
        t65 = '0;
        sv  = '0;
        unique case (op_reg)
            wual_pkg::OP_ADD: begin
                t65 = {1'b0, a_dat} + {1'b0, b_dat} + 65'(cy_reg);
                sv  = t65[63:0];
            end
            wual_pkg::OP_SUB: begin
                t65 = {1'b0, a_dat} - {1'b0, b_dat} - 65'(cy_reg);
                sv  = t65[63:0];
            end
            wual_pkg::OP_NEG: begin
                t65 = 65'd0 - {1'b0, a_dat} - 65'(cy_reg);
                sv  = t65[63:0];
            end
            wual_pkg::OP_AND: sv = a_dat & b_dat;
            wual_pkg::OP_OR:  sv = a_dat | b_dat;
            wual_pkg::OP_XOR: sv = a_dat ^ b_dat;
            wual_pkg::OP_NOT: sv = ~a_dat;
            wual_pkg::OP_SHL: begin
                sv = big ? '0 : ((sh_cur << bs) | ((bs != 6'd0) ? (prev_reg >> nbs) : '0));
            end
            wual_pkg::OP_SHR: begin
                sv = big ? '0 : ((sh_cur >> bs) | ((bs != 6'd0) ? (prev_reg << nbs) : '0));
            end
            default: sv = '0;
        endcase
        cy_s = t65[64];
    end

    assign m_s    = {r_dat[62:0], sc_reg};
    assign m_t    = {1'b0, m_s} + {1'b0, (opw_reg[bit_reg[5:0]] ? a_dat : 64'd0)}
                    + 65'(cy_reg);
    assign d_s    = {c_dat[62:0], sc_reg};
    assign d_t    = {1'b0, d_s} - {1'b0, b_dat} - 65'(cy_reg);
    assign accept = c_dat[63] | ~d_t[64];
    assign cy_p   = (ph_reg == PH_SIMPLE) ? cy_s : (ph_reg == PH_MUL) ? m_t[64] : d_t[64];
    assign sc_p   = (ph_reg == PH_MUL) ? r_dat[63] : c_dat[63];

    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        op_next      = op_reg;
        sh_next      = sh_reg;
        k_next       = k_reg;
        bit_next     = bit_reg;
        first_next   = first_reg;
        cur_sel_next = cur_sel_reg;
        dz_next      = dz_reg;
        cy_next      = cy_reg;
        sc_next      = sc_reg;
        gt_next      = gt_reg;
        done_next    = done_reg;
        nz_next      = nz_reg;
        opw_next     = opw_reg;
        q_next       = q_reg;
        prev_next    = prev_reg;
        q_we         = 1'b0;
        if (proc_v_reg) begin
            cy_next   = cy_p;
            sc_next   = sc_p;
            prev_next = sh_cur;
            nz_next   = nz_reg | (b_dat != '0);
            if (ph_reg == PH_CMP && !done_reg) begin
                if (a_dat > b_dat) begin
                    gt_next   = 1'b1;
                    done_next = 1'b1;
                end else if (a_dat < b_dat) begin
                    done_next = 1'b1;
                end
            end
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    op_next      = cmd_opcode;
                    sh_next      = cmd_shift_amount;
                    dz_next      = 1'b0;
                    gt_next      = 1'b0;
                    done_next    = 1'b0;
                    nz_next      = 1'b0;
                    k_next       = '0;
                    cy_next      = 1'b0;
                    sc_next      = 1'b0;
                    prev_next    = '0;
                    first_next   = 1'b1;
                    cur_sel_next = 1'b0;
                    bit_next     = BIT_TOP;
                    case (cmd_opcode)
                        wual_pkg::OP_ADD, wual_pkg::OP_SUB, wual_pkg::OP_AND,
                        wual_pkg::OP_OR, wual_pkg::OP_XOR, wual_pkg::OP_NOT,
                        wual_pkg::OP_NEG, wual_pkg::OP_SHL, wual_pkg::OP_SHR: begin
                            ph_next    = PH_SIMPLE;
                            state_next = ST_PASS;
                        end
                        wual_pkg::OP_CMP: begin
                            ph_next    = PH_CMP;
                            state_next = ST_PASS;
                        end
                        wual_pkg::OP_DIV, wual_pkg::OP_MOD: begin
                            ph_next    = PH_ZERO;
                            state_next = ST_PASS;
                        end
                        wual_pkg::OP_MUL: begin
                            ph_next    = PH_MUL;
                            state_next = ST_FETCH;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PASS: begin
                if (k_reg == LAST_IDX) begin
                    k_next     = '0;
                    state_next = ST_FIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_FIN: begin
                case (ph_reg)
                    PH_SIMPLE: state_next = ST_EMIT;
                    PH_CMP:    state_next = ST_CMPOUT;
                    PH_ZERO: begin
                        if (nz_reg || (b_dat != '0)) begin
                            ph_next      = PH_DIV;
                            bit_next     = BIT_TOP;
                            first_next   = 1'b1;
                            cur_sel_next = 1'b0;
                            state_next   = ST_FETCH;
                        end else begin
                            dz_next    = 1'b1;
                            state_next = ST_EMIT;
                        end
                    end
                    PH_MUL, PH_DIV: begin
                        if (ph_reg == PH_DIV) begin
                            cur_sel_next = accept ? ~cur_sel_reg : cur_sel_reg;
                            q_next       = {q_reg[62:0], accept};
                            q_we         = (bit_reg[5:0] == 6'd0);
                        end
                        if (bit_reg == '0) begin
                            state_next = ST_EMIT;
                        end else begin
                            bit_next   = bit_dec;
                            first_next = 1'b0;
                            if (bit_reg[5:0] == 6'd0) begin
                                state_next = ST_FETCH;
                            end else begin
                                cy_next    = 1'b0;
                                prev_next  = '0;
                                sc_next    = (ph_reg == PH_DIV) && opw_reg[bit_dec[5:0]];
                                state_next = ST_PASS;
                            end
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_FETCH: state_next = ST_FETCH2;
            ST_FETCH2: begin
                opw_next   = fw;
                cy_next    = 1'b0;
                prev_next  = '0;
                sc_next    = (ph_reg == PH_DIV) && fw[bit_reg[5:0]];
                k_next     = '0;
                state_next = ST_PASS;
            end
            ST_EMIT: state_next = ST_EMIT2;
            ST_EMIT2: begin
                if (res_ready) begin
                    if (k_reg == LAST_IDX) begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CMPOUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_we  = (proc_v_reg && (ph_reg == PH_SIMPLE || ph_reg == PH_MUL)) || q_we;
    assign res_wa  = q_we ? bword : widx_d_reg;
    assign res_wd  = q_we ? {q_reg[62:0], accept} : ((ph_reg == PH_MUL) ? m_t[63:0] : sv);
    assign rem_we  = proc_v_reg && (ph_reg == PH_DIV);
    assign rem0_wd = cur_sel_reg ? d_t[63:0] : d_s;
    assign rem1_wd = cur_sel_reg ? d_s : d_t[63:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            proc_v_reg <= 1'b0;
            a_vld_reg  <= '0;
            b_vld_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            proc_v_reg <= (state_reg == ST_PASS);
            a_vld_reg  <= a_vld_next;
            b_vld_reg  <= b_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_ok_reg     <= a_vld_reg[a_ra];
        b_ok_reg     <= b_vld_reg[b_ra];
        widx_d_reg   <= widx;
        ok_d_reg     <= src_ok;
        ph_reg       <= ph_next;
        op_reg       <= op_next;
        sh_reg       <= sh_next;
        k_reg        <= k_next;
        bit_reg      <= bit_next;
        first_reg    <= first_next;
        cur_sel_reg  <= cur_sel_next;
        dz_reg       <= dz_next;
        cy_reg       <= cy_next;
        sc_reg       <= sc_next;
        gt_reg       <= gt_next;
        done_reg     <= done_next;
        nz_reg       <= nz_next;
        opw_reg      <= opw_next;
        q_reg        <= q_next;
        prev_reg     <= prev_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT2) || (state_reg == ST_CMPOUT);
    assign emit_rem  = (ph_reg == PH_DIV) && (op_reg == wual_pkg::OP_MOD);

    always_comb begin
        if (state_reg == ST_CMPOUT) begin
            res_item.word  = '0;
            res_item.index = '0;
            res_item.last  = 1'b1;
            res_item.gt    = gt_reg;
            res_item.eq    = !done_reg;
            res_item.dz    = 1'b0;
        end else begin
            res_item.word  = dz_reg ? '1 : (emit_rem ? cur_rd : r_rd);
            res_item.index = 4'(k_reg);
            res_item.last  = (k_reg == LAST_IDX);
            res_item.gt    = 1'b0;
            res_item.eq    = 1'b0;
            res_item.dz    = dz_reg;
        end
    end

endmodule

FILE: rtl/wide_unsigned_integer_alu_unit.sv
// ----------------------------------------------------------------------------
// Wide unsigned integer ALU unit
// Top level with the stream ports and the registered result stage.
// ----------------------------------------------------------------------------
// The input stream carries one command per transaction. Loads write one
// 64-bit word of operand A or B and produce no output.
// Execute commands compute on A and B and return NWORDS = WIDTH_BITS/64
// result transactions, least significant word first, m_tlast on the last.
// Compare returns one transaction with the flags.
// Add, subtract, logic, negate, shift and compare make one pass through the
// operand and work memories at one word per cycle before the first result
// transaction is offered.
// Multiply and divide/remainder work bit-serially: each of the WIDTH_BITS
// bits costs one word-serial read-modify-write pass, plus a fetch of the
// next bit word every 64 bits; divide adds one scan of B for the zero check.
// Results leave one word at a time through the output register.
// s_tready is high while no command is in progress, also when a result
// still waits in the output register. A stalled receiver holds the engine.
// Reset clears the control state and makes both operands read as zero.
module wide_unsigned_integer_alu_unit #(
    parameter int WIDTH_BITS = wual_pkg::DEF_WIDTH_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // word_index [3:0], data_word [67:4], shift_amount [77:68]
    input  logic [wual_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode [3:0]
    input  logic [wual_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_word [63:0], result_index [67:64]
    output logic [wual_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // a_greater [0], a_equal [1], divide_by_zero [2]
    output logic [wual_pkg::M_TUSER_W-1:0] m_tuser
);

    logic           res_valid, res_ready;
    wual_pkg::res_t res_item;
    wual_pkg::res_t m_item_reg;
    logic           m_tvalid_reg;

    wual_core #(
        .WIDTH_BITS(WIDTH_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (s_tvalid),
        .cmd_ready        (s_tready),
        .cmd_opcode       (s_tuser),
        .cmd_word_index   (s_tdata[3:0]),
        .cmd_data_word    (s_tdata[67:4]),
        .cmd_shift_amount (s_tdata[77:68]),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res_item         (res_item)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_item_reg.index, m_item_reg.word};
    assign m_tlast  = m_item_reg.last;
    assign m_tuser  = {m_item_reg.dz, m_item_reg.eq, m_item_reg.gt};

endmodule

FILE: rtl/wual_checker.sv
// ----------------------------------------------------------------------------
// Wide unsigned integer ALU checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wual_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [wual_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [wual_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wual_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic [wual_pkg::M_TUSER_W-1:0] m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("greater and equal both set");

    a_cmp_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tlast && (m_tdata == '0) && !m_tuser[2])
        else $error("compare transaction malformed");

    a_dz_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> (m_tdata[63:0] == '1))
        else $error("divide by zero result not all ones");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wide_unsigned_integer_alu_unit wual_checker u_wual_checker (.*);

FILE: test/wide_unsigned_integer_alu_unit_tb.sv
// ----------------------------------------------------------------------------
// Wide unsigned integer ALU unit testbench
// Loads operand words and issues every command against the default 1024-bit
// unit. A scoreboard keeps its own copy of both operands, computes each
// result with native wide arithmetic and compares every result transaction
// field by field. Both stream sides idle at random, and the receiver holds
// off once for a long stretch so that the unit stalls its input.
// ----------------------------------------------------------------------------
module wide_unsigned_integer_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BITS  = wual_pkg::DEF_WIDTH_BITS;
    localparam int NUM_WORDS = wual_pkg::DEF_WIDTH_BITS / wual_pkg::WORD_W;
    localparam int IDLE_LIMIT = 200000;

    class alu_scoreboard;
        logic [NUM_BITS-1:0] reg_a;
        logic [NUM_BITS-1:0] reg_b;
        wual_pkg::res_t      expected_words[$];
        int                  mismatches;

        function new();
            reg_a = '0;
            reg_b = '0;
            mismatches = 0;
        endfunction

        function void note_command(logic [wual_pkg::OPCODE_W-1:0] op,
                                   logic [wual_pkg::INDEX_W-1:0] idx,
                                   logic [wual_pkg::WORD_W-1:0] data,
                                   logic [wual_pkg::SHAMT_W-1:0] shamt);
            logic [NUM_BITS-1:0] value;
            logic                zero_div;
            wual_pkg::res_t      item;
            value = '0;
            zero_div = 1'b0;
            case (op)
                wual_pkg::OP_LOAD_A: begin
                    reg_a[idx*wual_pkg::WORD_W +: wual_pkg::WORD_W] = data;
                    return;
                end
                wual_pkg::OP_LOAD_B: begin
                    reg_b[idx*wual_pkg::WORD_W +: wual_pkg::WORD_W] = data;
                    return;
                end
                wual_pkg::OP_ADD: value = reg_a + reg_b;
                wual_pkg::OP_SUB: value = reg_a - reg_b;
                wual_pkg::OP_MUL: value = reg_a * reg_b;
                wual_pkg::OP_DIV, wual_pkg::OP_MOD: begin
                    if (reg_b == '0) begin
                        value = '1;
                        zero_div = 1'b1;
                    end else if (op == wual_pkg::OP_DIV) begin
                        value = reg_a / reg_b;
                    end else begin
                        value = reg_a % reg_b;
                    end
                end
                wual_pkg::OP_AND: value = reg_a & reg_b;
                wual_pkg::OP_OR:  value = reg_a | reg_b;
                wual_pkg::OP_XOR: value = reg_a ^ reg_b;
                wual_pkg::OP_NOT: value = ~reg_a;
                wual_pkg::OP_NEG: value = '0 - reg_a;
                wual_pkg::OP_SHL: value = (shamt >= NUM_BITS) ? '0 : reg_a << shamt;
                wual_pkg::OP_SHR: value = (shamt >= NUM_BITS) ? '0 : reg_a >> shamt;
                wual_pkg::OP_CMP: begin
                    item = '0;
                    item.last = 1'b1;
                    item.gt = reg_a > reg_b;
                    item.eq = reg_a == reg_b;
                    expected_words.push_back(item);
                    return;
                end
                default: return;
            endcase
            for (int i = 0; i < NUM_WORDS; i++) begin
                item = '0;
                item.word = value[i*wual_pkg::WORD_W +: wual_pkg::WORD_W];
                item.index = i[wual_pkg::INDEX_W-1:0];
                item.last = (i == NUM_WORDS - 1);
                item.dz = zero_div;
                expected_words.push_back(item);
            end
        endfunction

        function void check_result(wual_pkg::res_t got);
            wual_pkg::res_t want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", got);
                return;
            end
            want = expected_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected word=%h idx=%0d last=%b gt=%b",
                              " eq=%b dz=%b, got word=%h idx=%0d last=%b gt=%b eq=%b dz=%b"},
                             want.word, want.index, want.last, want.gt, want.eq, want.dz,
                             got.word, got.index, got.last, got.gt, got.eq, got.dz);
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [wual_pkg::S_TDATA_W-1:0] s_tdata;
    logic [wual_pkg::S_TUSER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [wual_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic [wual_pkg::M_TUSER_W-1:0] m_tuser;

    alu_scoreboard sb = new();
    int            idle_cycles;
    int            results_seen = 0;

    wide_unsigned_integer_alu_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        wual_pkg::res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.word = m_tdata[63:0];
            got.index = m_tdata[67:64];
            got.last = m_tlast;
            got.gt = m_tuser[0];
            got.eq = m_tuser[1];
            got.dz = m_tuser[2];
            sb.check_result(got);
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("wide_unsigned_integer_alu_unit test failed");
                $finish;
            end
        end
    end

    function automatic logic [wual_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic send_command(logic [wual_pkg::OPCODE_W-1:0] op,
                                logic [wual_pkg::INDEX_W-1:0] idx,
                                logic [wual_pkg::WORD_W-1:0] data,
                                logic [wual_pkg::SHAMT_W-1:0] shamt,
                                bit allow_gap);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, shamt, data, idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(op, idx, data, shamt);
        gap = allow_gap ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic load_operand(logic [wual_pkg::OPCODE_W-1:0] op,
                                logic [wual_pkg::WORD_W-1:0] data);
        for (int i = 0; i < NUM_WORDS; i++)
            send_command(op, i[wual_pkg::INDEX_W-1:0], data, '0, 1'b0);
    endtask

    initial begin
        bit busy_phase;
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_seen > 40 && !busy_phase) begin
                busy_phase = 1'b1;
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [wual_pkg::OPCODE_W-1:0] op;
        int                            issued;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_command(wual_pkg::OP_CMP, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_DIV, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_MOD, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_LOAD_A, 4'd15, '1, '0, 1'b1);
        send_command(wual_pkg::OP_LOAD_A, 4'd0, '1, '0, 1'b1);
        send_command(wual_pkg::OP_LOAD_B, 4'd0, 64'd3, '0, 1'b1);
        send_command(wual_pkg::OP_ADD, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_SUB, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_MUL, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_DIV, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_MOD, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_AND, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_OR, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_XOR, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_NOT, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_NEG, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_SHL, '0, '0, 10'd0, 1'b1);
        send_command(wual_pkg::OP_SHL, '0, '0, 10'd1023, 1'b1);
        send_command(wual_pkg::OP_SHR, '0, '1, 10'd1023, 1'b1);
        send_command(wual_pkg::OP_SHR, '0, '0, 10'd65, 1'b1);
        send_command(wual_pkg::OP_CMP, '0, '0, '0, 1'b1);
        send_command(4'd15, '1, '1, '1, 1'b1);
        load_operand(wual_pkg::OP_LOAD_B, '1);
        load_operand(wual_pkg::OP_LOAD_A, '1);
        send_command(wual_pkg::OP_CMP, '0, '0, '0, 1'b1);
        send_command(wual_pkg::OP_ADD, '0, '0, '0, 1'b1);

        issued = 0;
        while (issued < 44) begin
            if ($urandom_range(0, 9) < 6) begin
                op = $urandom_range(0, 1) ? wual_pkg::OP_LOAD_A : wual_pkg::OP_LOAD_B;
            end else if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 2) == 0)
                    op = wual_pkg::OP_MUL;
                else
                    op = $urandom_range(0, 1) ? wual_pkg::OP_DIV : wual_pkg::OP_MOD;
            end else begin
                case ($urandom_range(0, 10))
                    0: op = wual_pkg::OP_ADD;
                    1: op = wual_pkg::OP_SUB;
                    2: op = wual_pkg::OP_AND;
                    3: op = wual_pkg::OP_OR;
                    4: op = wual_pkg::OP_XOR;
                    5: op = wual_pkg::OP_NOT;
                    6: op = wual_pkg::OP_NEG;
                    7: op = wual_pkg::OP_SHL;
                    8: op = wual_pkg::OP_SHR;
                    9: op = wual_pkg::OP_CMP;
                    default: op = 4'd15;
                endcase
            end
            send_command(op, 4'($urandom_range(0, 15)), pick_word(),
                         10'($urandom_range(0, 1023)), $urandom_range(0, 3) != 0);
            issued++;
        end
        s_tvalid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("wide_unsigned_integer_alu_unit test passed");
        end else begin
            $display("wide_unsigned_integer_alu_unit test failed");
        end
        $finish;
    end

endmodule
